// ===== src/adv_spam_burst_detector_defines.svh =====
// Assertion macros used by the burst detector top module.
// Expects clk and rst_n in the scope of each use.
`ifndef ADV_SPAM_BURST_DETECTOR_DEFINES_SVH
`define ADV_SPAM_BURST_DETECTOR_DEFINES_SVH

// Same-cycle implication.
`define ASBD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASBD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/asbd_pkg.sv =====
// Types, sizes and register codes of the advertisement burst detector.
// No dependencies; used by every other file except the assertion macro header.
package asbd_pkg;

    localparam int SLOTS         = 16;
    localparam int COMPARE_BYTES = 16;

    localparam int BYTE_W  = 8;
    localparam int TICK_W  = 32;
    localparam int DIFF_W  = 5;
    localparam int OUT_W   = 5;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 4;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int POS_W   = $clog2(COMPARE_BYTES + 1);
    localparam int IDX_W   = (COMPARE_BYTES > 1) ? $clog2(COMPARE_BYTES) : 1;
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int CMP_W   = (CNT_W > DIFF_W) ? CNT_W : DIFF_W;
    localparam int OUT_MAX = 31;

    localparam logic [DIFF_W-1:0] DIFF_MAX        = DIFF_W'(31);
    localparam logic [TICK_W-1:0] WINDOW_RESET    = TICK_W'(1000);
    localparam logic [DIFF_W-1:0] MAX_DIFF_RESET  = DIFF_W'(3);
    localparam logic [DIFF_W-1:0] THRESHOLD_RESET = DIFF_W'(5);

    typedef enum logic [1:0] {
        REG_WINDOW    = 2'd0,
        REG_MAX_DIFF  = 2'd1,
        REG_THRESHOLD = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [TICK_W-1:0] window;
        logic [DIFF_W-1:0] max_diff;
        logic [DIFF_W-1:0] threshold;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              empty;
        logic [TICK_W-1:0] tick;
        logic [POS_W-1:0]  pos;
        logic [SLOT_W-1:0] wslot;
        logic [CNT_W-1:0]  count;
    } bus_t;

endpackage

// ===== src/asbd_if.sv =====
// Valid/ready channels of the burst detector: request in, result out.
// Depends on asbd_pkg.
interface asbd_req_if;
    import asbd_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] payload_byte;
    logic              last_byte;
    logic              empty_payload;
    logic [TICK_W-1:0] now_tick;

    modport source (output valid, payload_byte, last_byte, empty_payload, now_tick,
                    input ready);
    modport sink (input valid, payload_byte, last_byte, empty_payload, now_tick,
                  output ready);
endinterface

interface asbd_res_if;
    import asbd_pkg::*;
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] similar_count;
    logic             spam_detected;

    modport source (output valid, similar_count, spam_detected, input ready);
    modport sink (input valid, similar_count, spam_detected, output ready);
endinterface

// ===== src/asbd_cfg.sv =====
// APB-style configuration registers of the burst detector.
// Depends on asbd_pkg.
module asbd_cfg (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [asbd_pkg::ADDR_W-1:0] paddr,
    input  logic [asbd_pkg::DATA_W-1:0] pwdata,
    output logic [asbd_pkg::DATA_W-1:0] prdata,
    output logic                      pready,
    output asbd_pkg::cfg_t            cfg
);
    import asbd_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t sel;
    logic     wr;

    assign sel    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            case (sel)
                REG_WINDOW:    cfg_next.window    = pwdata[TICK_W-1:0];
                REG_MAX_DIFF:  cfg_next.max_diff  = pwdata[DIFF_W-1:0];
                REG_THRESHOLD: cfg_next.threshold = pwdata[DIFF_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            REG_WINDOW:    prdata = DATA_W'(cfg_reg.window);
            REG_MAX_DIFF:  prdata = DATA_W'(cfg_reg.max_diff);
            REG_THRESHOLD: prdata = DATA_W'(cfg_reg.threshold);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window    <= WINDOW_RESET;
            cfg_reg.max_diff  <= MAX_DIFF_RESET;
            cfg_reg.threshold <= THRESHOLD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== src/asbd_cell.sv =====
// One slot of the detector chain: stored prefix, time and difference count.
// Depends on asbd_pkg.
module asbd_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  asbd_pkg::cfg_t cfg,
    input  asbd_pkg::bus_t bus_in,
    output asbd_pkg::bus_t bus_out
);
    import asbd_pkg::*;

    logic [BYTE_W-1:0] prefix_reg [COMPARE_BYTES];
    logic [TICK_W-1:0] time_reg;
    logic [DIFF_W-1:0] diff_reg;
    logic [DIFF_W-1:0] diff_next;
    bus_t              bus_reg;
    bus_t              bus_next;

    logic              byte_ok;
    logic              own;
    logic              fin;
    logic              hit;
    logic [IDX_W-1:0]  idx;
    logic [DIFF_W-1:0] diff_step;
    logic [TICK_W-1:0] age;

    assign idx     = bus_in.pos[IDX_W-1:0];
    assign byte_ok = bus_in.valid && !bus_in.empty
                     && (bus_in.pos < POS_W'(COMPARE_BYTES));
    assign own     = (bus_in.wslot == '0);
    assign fin     = bus_in.valid && (bus_in.last || bus_in.empty);
    assign age     = bus_in.tick - time_reg;

    always_comb
    begin
        diff_step = diff_reg;
        if (byte_ok && (prefix_reg[idx] != bus_in.data) && (diff_reg != DIFF_MAX))
        begin
            diff_step = diff_reg + DIFF_W'(1);
        end
        hit       = (age < cfg.window) && (diff_step <= cfg.max_diff);
        diff_next = fin ? '0 : diff_step;

        bus_next       = bus_in;
        bus_next.wslot = bus_in.wslot - SLOT_W'(1);
        bus_next.count = bus_in.count + CNT_W'(fin && hit);
    end

    assign bus_out = bus_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_reg  <= '0;
            diff_reg <= '0;
            time_reg <= '0;
            for (int i = 0; i < COMPARE_BYTES; i++)
            begin
                prefix_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            bus_reg  <= bus_next;
            diff_reg <= diff_next;
            if (byte_ok && own)
            begin
                prefix_reg[idx] <= bus_in.data;
            end
            if (fin && own)
            begin
                time_reg <= bus_in.tick;
            end
        end
    end

endmodule

// ===== src/adv_spam_burst_detector.sv =====
// Advertisement burst detector: a chain of SLOTS cells, one per stored payload.
// Path: the final request of a payload passes each cell's bus register, then the result register.
// Throughput: one request per cycle; the whole chain holds while a result waits.
// Reset clears every stored byte, time, count, the slot and position counters,
// and loads the register defaults. Depends on asbd_pkg, asbd_if, asbd_cfg, asbd_cell.
module adv_spam_burst_detector (
    input  logic                        clk,
    input  logic                        rst_n,
    asbd_req_if.sink                    request,
    asbd_res_if.source                  result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [asbd_pkg::ADDR_W-1:0] paddr,
    input  logic [asbd_pkg::DATA_W-1:0] pwdata,
    output logic [asbd_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import asbd_pkg::*;
    `include "adv_spam_burst_detector_defines.svh"

    cfg_t              cfg;
    bus_t              chain [SLOTS+1];
    logic              stall;
    logic              advance;
    logic              accept;
    logic              fin_in;
    logic              tail_fin;

    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [SLOT_W-1:0] wslot_reg;
    logic [SLOT_W-1:0] wslot_next;

    logic              res_valid_reg;
    logic [OUT_W-1:0]  count_reg;
    logic [OUT_W-1:0]  count_next;
    logic              spam_reg;
    logic              spam_next;

    asbd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign stall         = res_valid_reg && !result.ready;
    assign advance       = !stall;
    assign request.ready = !stall;
    assign accept        = request.valid && !stall;
    assign fin_in        = request.last_byte || request.empty_payload;

    always_comb
    begin
        pos_next   = pos_reg;
        wslot_next = wslot_reg;
        if (accept)
        begin
            if (fin_in)
            begin
                pos_next   = '0;
                wslot_next = (wslot_reg == SLOT_W'(SLOTS - 1)) ? '0 : wslot_reg + SLOT_W'(1);
            end
            else if (pos_reg < POS_W'(COMPARE_BYTES))
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_comb
    begin
        chain[0].valid = accept;
        chain[0].data  = request.payload_byte;
        chain[0].last  = request.last_byte;
        chain[0].empty = request.empty_payload;
        chain[0].tick  = request.now_tick;
        chain[0].pos   = pos_reg;
        chain[0].wslot = wslot_reg;
        chain[0].count = '0;
    end

    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        asbd_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .cfg     (cfg),
            .bus_in  (chain[g]),
            .bus_out (chain[g+1])
        );
    end

    assign tail_fin   = chain[SLOTS].valid && (chain[SLOTS].last || chain[SLOTS].empty);
    assign count_next = (CMP_W'(chain[SLOTS].count) > CMP_W'(OUT_MAX))
                        ? OUT_W'(OUT_MAX) : OUT_W'(chain[SLOTS].count);
    assign spam_next  = CMP_W'(chain[SLOTS].count) >= CMP_W'(cfg.threshold);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            wslot_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            wslot_reg <= wslot_next;
            if (advance)
            begin
                res_valid_reg <= tail_fin;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            count_reg <= count_next;
            spam_reg  <= spam_next;
        end
    end

    assign result.valid         = res_valid_reg;
    assign result.similar_count = count_reg;
    assign result.spam_detected = spam_reg;

    `ASBD_ASSERT_IMP(a_pos_range, 1'b1, pos_reg <= POS_W'(COMPARE_BYTES), "position overrun")
    `ASBD_ASSERT_NXT(a_end_clears_pos, accept && fin_in, pos_reg == '0, "position not cleared")
    `ASBD_ASSERT_NXT(a_slot_hold, !(accept && fin_in), $stable(wslot_reg), "slot moved early")
    `ASBD_ASSERT_NXT(a_chain_freeze, stall, $stable(chain[SLOTS].count), "chain moved on stall")

endmodule
